// ===== design/mdu_pkg.sv =====
// shared types and codes for the rv32m multiply/divide pipeline
package mdu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned DIV_STEPS = XLEN;
  localparam logic [6:0] FUNCT7_MULDIV = 7'd1;

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } op_e;

  typedef struct packed {
    logic      valid;
    logic      illegal;
    op_e       op;
    logic      neg_res;
    logic      div_zero;
  } ctl_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [2*XLEN-1:0] prod;
    logic [XLEN-1:0]   rem;
    logic [XLEN-1:0]   quo;
    logic [XLEN-1:0]   dvs;
  } pipe_t;

endpackage

// ===== design/mdu_decode.sv =====
// first stage: operation decode, operand magnitudes and sign of the result
module mdu_decode (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_i,
  input  logic [2:0]               req_type_i,
  input  logic [6:0]               funct_seven_i,
  input  logic [mdu_pkg::XLEN-1:0] operand_a_i,
  input  logic [mdu_pkg::XLEN-1:0] operand_b_i,
  output mdu_pkg::ctl_t            ctl_o,
  output logic [mdu_pkg::XLEN-1:0] mag_a_o,
  output logic [mdu_pkg::XLEN-1:0] mag_b_o
);
  import mdu_pkg::*;

  op_e             op;
  logic            sgn_a;
  logic            sgn_b;
  logic            neg_a;
  logic            neg_b;
  ctl_t            ctl_d;
  ctl_t            ctl_q;
  logic [XLEN-1:0] mag_a_d;
  logic [XLEN-1:0] mag_b_d;
  logic [XLEN-1:0] mag_a_q;
  logic [XLEN-1:0] mag_b_q;

  always_comb begin
    op = op_e'(req_type_i);
    sgn_a = 1'b0;
    sgn_b = 1'b0;
    case (op)
      OP_MULH, OP_DIV, OP_REM: begin
        sgn_a = 1'b1;
        sgn_b = 1'b1;
      end
      OP_MULHSU: begin
        sgn_a = 1'b1;
      end
      default: begin
        sgn_a = 1'b0;
      end
    endcase
    neg_a = sgn_a & operand_a_i[XLEN-1];
    neg_b = sgn_b & operand_b_i[XLEN-1];
    mag_a_d = neg_a ? (XLEN'(0) - operand_a_i) : operand_a_i;
    mag_b_d = neg_b ? (XLEN'(0) - operand_b_i) : operand_b_i;
    ctl_d.valid    = req_i;
    ctl_d.illegal  = (funct_seven_i != FUNCT7_MULDIV);
    ctl_d.op       = op;
    ctl_d.neg_res  = (op == OP_REM) ? neg_a : (neg_a ^ neg_b);
    ctl_d.div_zero = (operand_b_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
  end

  assign ctl_o   = ctl_q;
  assign mag_a_o = mag_a_q;
  assign mag_b_o = mag_b_q;

endmodule

// ===== design/mdu_mult.sv =====
// second stage: magnitude product and divider initial state
module mdu_mult (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mdu_pkg::ctl_t            ctl_i,
  input  logic [mdu_pkg::XLEN-1:0] mag_a_i,
  input  logic [mdu_pkg::XLEN-1:0] mag_b_i,
  output mdu_pkg::pipe_t           pipe_o
);
  import mdu_pkg::*;

  pipe_t pipe_d;
  pipe_t pipe_q;

  always_comb begin
    pipe_d.ctl  = ctl_i;
    pipe_d.prod = (2*XLEN)'(mag_a_i) * (2*XLEN)'(mag_b_i);
    pipe_d.rem  = '0;
    pipe_d.quo  = mag_a_i;
    pipe_d.dvs  = mag_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

// ===== design/mdu_div_step.sv =====
// one registered restoring division step, one quotient bit
module mdu_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mdu_pkg::pipe_t pipe_i,
  output mdu_pkg::pipe_t pipe_o
);
  import mdu_pkg::*;

  logic [XLEN:0] trial;
  logic [XLEN:0] diff;
  logic          fits;
  pipe_t         pipe_d;
  pipe_t         pipe_q;

  always_comb begin
    trial  = {pipe_i.rem, pipe_i.quo[XLEN-1]};
    diff   = trial - {1'b0, pipe_i.dvs};
    fits   = ~diff[XLEN];
    pipe_d = pipe_i;
    pipe_d.rem = fits ? diff[XLEN-1:0] : trial[XLEN-1:0];
    pipe_d.quo = {pipe_i.quo[XLEN-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= '0;
    end else begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule

// ===== design/rv32_multiply_divide_unit.sv =====
// top level of the pipelined rv32m multiply/divide unit
//
// a request is taken at a rising edge with start high and busy low;
// busy is always low, so a new request can enter every cycle
// request fields: req_type_i, funct_seven_i, operand_a_i, operand_b_i
// every request gives exactly one result on result_value_o and illegal_o,
// shown for one cycle with valid_o high, in request order
// every operation passes the same stages: decode, multiply,
// 32 restoring division steps (one quotient bit per stage) and output
// throughput is one request per cycle; the division chain sets the latency
// an illegal function-7 field gives illegal_o high and a zero result
// reset clears all stage valid bits; requests in flight are dropped
// the receiver cannot stall, so the pipeline never holds
module rv32_multiply_divide_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               req_type_i,
  input  logic [6:0]               funct_seven_i,
  input  logic [mdu_pkg::XLEN-1:0] operand_a_i,
  input  logic [mdu_pkg::XLEN-1:0] operand_b_i,
  output logic                     valid_o,
  output logic [mdu_pkg::XLEN-1:0] result_value_o,
  output logic                     illegal_o
);
  import mdu_pkg::*;

  ctl_t              dec_ctl;
  logic [XLEN-1:0]   mag_a;
  logic [XLEN-1:0]   mag_b;
  pipe_t             stage [DIV_STEPS+1];
  pipe_t             last;
  logic [2*XLEN-1:0] prod_s;
  logic [XLEN-1:0]   quo_s;
  logic [XLEN-1:0]   rem_s;
  logic [XLEN-1:0]   res_d;
  logic [XLEN-1:0]   res_q;
  logic              ill_q;
  logic              vld_q;

  assign busy = 1'b0;

  mdu_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (start & ~busy),
    .req_type_i    (req_type_i),
    .funct_seven_i (funct_seven_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .ctl_o         (dec_ctl),
    .mag_a_o       (mag_a),
    .mag_b_o       (mag_b)
  );

  mdu_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (dec_ctl),
    .mag_a_i (mag_a),
    .mag_b_i (mag_b),
    .pipe_o  (stage[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    mdu_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pipe_i (stage[i]),
      .pipe_o (stage[i+1])
    );
  end

  assign last = stage[DIV_STEPS];

  always_comb begin
    prod_s = last.ctl.neg_res ? ((2*XLEN)'(0) - last.prod) : last.prod;
    quo_s  = last.ctl.neg_res ? (XLEN'(0) - last.quo) : last.quo;
    rem_s  = last.ctl.neg_res ? (XLEN'(0) - last.rem) : last.rem;
    case (last.ctl.op)
      OP_MUL:                   res_d = last.prod[XLEN-1:0];
      OP_MULH, OP_MULHSU:       res_d = prod_s[2*XLEN-1:XLEN];
      OP_MULHU:                 res_d = last.prod[2*XLEN-1:XLEN];
      OP_DIV:                   res_d = last.ctl.div_zero ? '1 : quo_s;
      OP_DIVU:                  res_d = last.ctl.div_zero ? '1 : last.quo;
      OP_REM:                   res_d = rem_s;
      OP_REMU:                  res_d = last.rem;
      default:                  res_d = '0;
    endcase
    if (last.ctl.illegal) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= last.ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ill_q <= last.ctl.illegal;
  end

  assign valid_o        = vld_q;
  assign result_value_o = res_q;
  assign illegal_o      = ill_q;

endmodule
